// ===== hdl/dfu_pkg.sv =====
// Shared types and constants for the DFU request engine.
package dfu_pkg;

   localparam logic [31:0] APP_START_RESET = 32'h0800_2000;

   typedef enum logic [2:0] {
      CMD_DNLOAD    = 3'd0,
      CMD_DATA      = 3'd1,
      CMD_GETSTATUS = 3'd2,
      CMD_CLRSTATUS = 3'd3,
      CMD_GETSTATE  = 3'd4,
      CMD_ABORT     = 3'd5,
      CMD_BUS_RESET = 3'd6,
      CMD_OTHER     = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ACK    = 3'd0,
      KIND_ERASE  = 3'd1,
      KIND_WRITE  = 3'd2,
      KIND_STATUS = 3'd3,
      KIND_STATE  = 3'd4,
      KIND_STALL  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_DN_SYNC  = 3'd1,
      MODE_DN_IDLE  = 3'd2,
      MODE_MAN_SYNC = 3'd3,
      MODE_MAN_WAIT = 3'd4,
      MODE_ERROR    = 3'd5
   } mode_type;

   typedef enum logic {
      STATUS_OK       = 1'b0,
      STATUS_ADDR_ERR = 1'b1
   } status_type;

   // One classified request: up to erase, write and a closing reply, in that order.
   typedef struct packed {
      logic        erase;
      logic        write;
      logic        tail;
      kind_type    tail_kind;
      logic [31:0] addr;
      logic [31:0] word;
      status_type  status;
      mode_type    mode;
      logic        rst_pend;
   } job_type;

endpackage

// ===== hdl/dfu_download_state_machine_top.sv =====
// Top level of the DFU download request engine.
//
// Request channel (req_*): one DFU class request per transaction, accepted at a
// rising edge with req_valid high and req_stall low. Result channel (rsp_*):
// erase, write, ack, status, state or stall transactions, taken at an edge with
// rsp_valid high and rsp_stall low; rsp_last marks the final one of a request.
// Bus reset and a download setup that opens a data stage produce no result.
// csr_*: write port for the application start address, used after clear status,
// abort and bus reset. A request passes the job queue, the back end's job
// register and the output register before its first result. Throughput: one
// request per cycle into a four-entry job queue while req_stall is low; the
// back end issues one result per cycle while rsp_stall is low, so a data word
// with erase, write and ack gives three results. A csr write holds req_stall
// high and csr_ready low while the remainder unit reduces the address modulo
// the page. Reset: state idle, status ok, address and start address 0x08002000,
// queue and output empty. While rsp_stall is high the output register holds
// its transaction and the queue keeps taking requests until it fills.
module dfu_download_state_machine_top import dfu_pkg::*; #(
   parameter int unsigned PAGE_BYTES     = 4096,
   parameter int unsigned TRANSFER_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_request_length,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_flash_address,
   output logic [31:0] rsp_flash_word,
   output logic        rsp_status_code,
   output logic [2:0]  rsp_state_code,
   output logic        rsp_reset_pending,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic    fifo_full;
   logic    fifo_push;
   job_type fifo_job;
   logic    fifo_pop;
   logic    head_valid;
   job_type head_job;

   dfu_front #(
      .PAGE_BYTES     (PAGE_BYTES),
      .TRANSFER_BYTES (TRANSFER_BYTES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_request_length (req_request_length),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_last_word      (req_last_word),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .fifo_full          (fifo_full),
      .fifo_push          (fifo_push),
      .fifo_job           (fifo_job)
   );

   dfu_fifo #(
      .DEPTH (4)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (fifo_push),
      .push_job   (fifo_job),
      .full       (fifo_full),
      .pop        (fifo_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   dfu_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_job          (head_job),
      .pop               (fifo_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_flash_address (rsp_flash_address),
      .rsp_flash_word    (rsp_flash_word),
      .rsp_status_code   (rsp_status_code),
      .rsp_state_code    (rsp_state_code),
      .rsp_reset_pending (rsp_reset_pending),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== hdl/dfu_page_rem.sv =====
// Remainder unit: start address modulo the page size by reciprocal multiplication.
module dfu_page_rem import dfu_pkg::*; #(
   parameter int unsigned PAGE_BYTES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [31:0]                       value,
   output logic                              busy,
   output logic [$clog2(PAGE_BYTES)-1:0]     rem
);

   localparam int unsigned OFF_W = $clog2(PAGE_BYTES);
   // ceil(2^(32+OFF_W) / PAGE_BYTES) gives the exact quotient of any 32-bit value
   localparam longint unsigned RECIP =
      ((64'd1 << (32 + OFF_W)) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
   localparam logic [64:0] RECIP_X = 65'(RECIP);
   localparam logic [31:0] PAGE_W  = 32'(PAGE_BYTES);
   localparam int unsigned START_OFF = APP_START_RESET % PAGE_BYTES;

   logic [OFF_W-1:0] rem_ff, rem_in;
   logic [31:0]      val_ff, val_in;
   logic [31:0]      quo_ff, quo_in;
   logic             phase_ff, phase_in;
   logic             busy_ff, busy_in;
   logic [64:0]      prod;
   logic [64:0]      quo_full;
   logic [31:0]      back_prod;
   logic [31:0]      diff;

   always_comb begin
      // both products are by constants: shift-and-add networks
      prod      = {33'd0, val_ff} * RECIP_X;
      quo_full  = prod >> (32 + OFF_W);
      back_prod = quo_ff * PAGE_W;
      diff      = val_ff - back_prod;
      rem_in    = rem_ff;
      val_in    = val_ff;
      quo_in    = quo_ff;
      phase_in  = phase_ff;
      busy_in   = busy_ff;
      if (start) begin
         val_in   = value;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            quo_in   = quo_full[31:0];
            phase_in = 1'b1;
         end else begin
            rem_in  = diff[OFF_W-1:0];
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= START_OFF[OFF_W-1:0];
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         rem_ff   <= rem_in;
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
      val_ff <= val_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign rem  = rem_ff;

endmodule

// ===== hdl/dfu_front.sv =====
// Front end: accepts requests, keeps DFU state, builds result jobs.
module dfu_front import dfu_pkg::*; #(
   parameter int unsigned PAGE_BYTES     = 4096,
   parameter int unsigned TRANSFER_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_request_length,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,
   input  logic        fifo_full,
   output logic        fifo_push,
   output job_type     fifo_job
);

   localparam int unsigned OFF_W = $clog2(PAGE_BYTES);
   localparam longint unsigned WRAP_REM = (64'd1 << 32) % PAGE_BYTES;
   localparam int unsigned WRAP_ADD = PAGE_BYTES - 32'(WRAP_REM);
   localparam int unsigned START_OFF = APP_START_RESET % PAGE_BYTES;
   localparam logic [OFF_W+1:0] PAGE_X  = PAGE_BYTES[OFF_W+1:0];
   localparam logic [OFF_W+1:0] PAGE2_X = PAGE_X << 1;
   localparam logic [OFF_W+1:0] WRAP_X  = WRAP_ADD[OFF_W+1:0];

   logic [31:0]      app_start_ff, app_start_in;
   mode_type         mode_ff, mode_in;
   status_type       status_ff, status_in;
   logic [31:0]      addr_ff, addr_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic             rflag_ff, rflag_in;

   logic             rem_busy;
   logic [OFF_W-1:0] start_off;
   logic             req_accept;
   logic             csr_accept;
   cmd_type          cmd;
   logic [2:0]       cnt;
   logic [32:0]      addr_sum;
   logic [OFF_W+1:0] off_sum;
   logic [OFF_W+1:0] off_wrap;
   logic [OFF_W-1:0] off_next;
   logic [31:0]      pad_word;
   logic             page_start;
   job_type          job;
   logic             has_result;

   dfu_page_rem #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_page_rem (
      .clock (clock),
      .reset (reset),
      .start (csr_accept),
      .value (csr_data),
      .busy  (rem_busy),
      .rem   (start_off)
   );

   assign cmd        = cmd_type'(req_command);
   assign req_stall  = fifo_full | rem_busy;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = ~rem_busy;
   assign csr_accept = csr_valid & csr_ready;
   assign page_start = (off_ff == '0);

   // byte count: zero writes nothing, above four counts as four
   always_comb begin
      if (req_byte_count > 3'd4) begin
         cnt = 3'd4;
      end else begin
         cnt = req_byte_count;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pad_word[8*i +: 8] = (3'(i) < cnt) ? req_data_word[8*i +: 8] : 8'hFF;
      end
   end

   // track address modulo page size; fold in 2^32 mod page on wrap
   always_comb begin
      addr_sum = {1'b0, addr_ff} + {30'd0, cnt};
      off_sum  = {2'b00, off_ff} + {{(OFF_W-1){1'b0}}, cnt};
      off_wrap = addr_sum[32] ? off_sum + WRAP_X : off_sum;
      if (off_wrap >= PAGE2_X) begin
         off_next = OFF_W'(off_wrap - PAGE2_X);
      end else if (off_wrap >= PAGE_X) begin
         off_next = OFF_W'(off_wrap - PAGE_X);
      end else begin
         off_next = off_wrap[OFF_W-1:0];
      end
   end

   // next state
   always_comb begin
      app_start_in = csr_accept ? csr_data : app_start_ff;
      mode_in      = mode_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      off_in       = off_ff;
      rflag_in     = rflag_ff;
      if (req_accept) begin
         unique case (cmd)
            CMD_DNLOAD: begin
               if (req_request_length == 16'd0) begin
                  mode_in = MODE_MAN_SYNC;
               end else if (req_request_length > TRANSFER_BYTES[15:0]) begin
                  mode_in   = MODE_ERROR;
                  status_in = STATUS_ADDR_ERR;
               end
            end
            CMD_DATA: begin
               if (cnt != 3'd0) begin
                  addr_in = addr_sum[31:0];
                  off_in  = off_next;
               end
               if (req_last_word) begin
                  mode_in = MODE_DN_SYNC;
               end
            end
            CMD_GETSTATUS: begin
               if (mode_ff == MODE_DN_SYNC) begin
                  mode_in = MODE_DN_IDLE;
               end else if (mode_ff == MODE_MAN_SYNC) begin
                  mode_in = MODE_MAN_WAIT;
               end
            end
            CMD_CLRSTATUS, CMD_ABORT, CMD_BUS_RESET: begin
               if (cmd == CMD_BUS_RESET && mode_ff == MODE_MAN_WAIT) begin
                  rflag_in = 1'b1;
               end
               mode_in   = MODE_IDLE;
               status_in = STATUS_OK;
               addr_in   = app_start_ff;
               off_in    = start_off;
            end
            CMD_GETSTATE, CMD_OTHER: begin
            end
            default: begin
            end
         endcase
      end
   end

   // job for the back end
   always_comb begin
      job           = '0;
      job.addr      = addr_ff;
      job.word      = pad_word;
      job.status    = status_ff;
      job.mode      = mode_ff;
      job.rst_pend  = rflag_ff;
      job.tail_kind = KIND_ACK;
      unique case (cmd)
         CMD_DNLOAD: begin
            if (req_request_length == 16'd0) begin
               job.tail = 1'b1;
            end else if (req_request_length > TRANSFER_BYTES[15:0]) begin
               job.tail      = 1'b1;
               job.tail_kind = KIND_STALL;
            end
         end
         CMD_DATA: begin
            job.erase = (cnt != 3'd0) & page_start;
            job.write = (cnt != 3'd0);
            job.tail  = req_last_word;
         end
         CMD_GETSTATUS: begin
            job.tail      = 1'b1;
            job.tail_kind = KIND_STATUS;
         end
         CMD_GETSTATE: begin
            job.tail      = 1'b1;
            job.tail_kind = KIND_STATE;
         end
         CMD_CLRSTATUS, CMD_ABORT: begin
            job.tail = 1'b1;
         end
         CMD_BUS_RESET: begin
         end
         CMD_OTHER: begin
            job.tail      = 1'b1;
            job.tail_kind = KIND_STALL;
         end
         default: begin
         end
      endcase
      has_result = job.erase | job.write | job.tail;
   end

   assign fifo_push = req_accept & has_result;
   assign fifo_job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         app_start_ff <= APP_START_RESET;
         mode_ff      <= MODE_IDLE;
         status_ff    <= STATUS_OK;
         addr_ff      <= APP_START_RESET;
         off_ff       <= START_OFF[OFF_W-1:0];
         rflag_ff     <= 1'b0;
      end else begin
         app_start_ff <= app_start_in;
         mode_ff      <= mode_in;
         status_ff    <= status_in;
         addr_ff      <= addr_in;
         off_ff       <= off_in;
         rflag_ff     <= rflag_in;
      end
   end

   a_no_accept_while_rem_busy : assert property (@(posedge clock) disable iff (reset)
      rem_busy |-> !req_accept)
      else $error("request accepted while page remainder unit busy");

   a_rflag_sticky : assert property (@(posedge clock) disable iff (reset)
      rflag_ff |=> rflag_ff)
      else $error("reset pending flag cleared outside reset");

endmodule

// ===== hdl/dfu_fifo.sv =====
// Short job queue between front and back ends.
module dfu_fifo import dfu_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_X  = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == DEPTH_X);
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("job pushed into full queue");

endmodule

// ===== hdl/dfu_back.sv =====
// Back end: expands queued jobs into result transactions through an output register.
module dfu_back import dfu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  job_type     head_job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_flash_address,
   output logic [31:0] rsp_flash_word,
   output logic        rsp_status_code,
   output logic [2:0]  rsp_state_code,
   output logic        rsp_reset_pending,
   output logic        rsp_last
);

   // pending bits: [0] erase, [1] write, [2] closing reply
   job_type     cur_ff, cur_in;
   logic [2:0]  pend_ff, pend_in;
   logic        valid_ff, valid_in;
   kind_type    kind_ff, kind_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] word_ff, word_in;
   logic        stat_ff, stat_in;
   logic [2:0]  state_ff, state_in;
   logic        rpend_ff, rpend_in;
   logic        last_ff, last_in;

   logic        out_free;
   logic        emit;
   logic [2:0]  pick;
   logic [2:0]  pend_after;

   assign out_free = ~valid_ff | ~rsp_stall;
   assign emit     = out_free & (pend_ff != 3'b000);

   always_comb begin
      priority if (pend_ff[0]) begin
         pick = 3'b001;
      end else if (pend_ff[1]) begin
         pick = 3'b010;
      end else begin
         pick = 3'b100;
      end
      pend_after = emit ? (pend_ff & ~pick) : pend_ff;
   end

   assign pop = (pend_after == 3'b000) & head_valid;

   always_comb begin
      cur_in   = cur_ff;
      pend_in  = pend_after;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      word_in  = word_ff;
      stat_in  = stat_ff;
      state_in = state_ff;
      rpend_in = rpend_ff;
      last_in  = last_ff;
      if (pop) begin
         cur_in  = head_job;
         pend_in = {head_job.tail, head_job.write, head_job.erase};
      end
      if (emit) begin
         valid_in = 1'b1;
         addr_in  = '0;
         word_in  = '0;
         stat_in  = 1'b0;
         state_in = '0;
         rpend_in = cur_ff.rst_pend;
         last_in  = (pend_after == 3'b000);
         unique case (pick)
            3'b001: begin
               kind_in = KIND_ERASE;
               addr_in = cur_ff.addr;
            end
            3'b010: begin
               kind_in = KIND_WRITE;
               addr_in = cur_ff.addr;
               word_in = cur_ff.word;
            end
            default: begin
               kind_in = cur_ff.tail_kind;
               if (cur_ff.tail_kind == KIND_STATUS || cur_ff.tail_kind == KIND_STATE) begin
                  stat_in  = cur_ff.status;
                  state_in = cur_ff.mode;
               end
            end
         endcase
      end else if (out_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 3'b000;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
      cur_ff   <= cur_in;
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      word_ff  <= word_in;
      stat_ff  <= stat_in;
      state_ff <= state_in;
      rpend_ff <= rpend_in;
      last_ff  <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_flash_address = addr_ff;
   assign rsp_flash_word    = word_ff;
   assign rsp_status_code   = stat_ff;
   assign rsp_state_code    = state_ff;
   assign rsp_reset_pending = rpend_ff;
   assign rsp_last          = last_ff;

   a_erase_not_last : assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_ERASE |-> !last_ff)
      else $error("erase transaction marked last");

   a_write_follows_erase : assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_ERASE && !rsp_stall |=> valid_ff && kind_ff == KIND_WRITE)
      else $error("erase not followed by write");

endmodule
